@@ rtl/core/cau_pkg.sv @@
package cau_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MAG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_SQRT = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Iterations of the shared divide and root steps.
  localparam int STEPS  = 32;
  localparam int STEP_W = $clog2(STEPS);

  // Limits of a 32-bit signed result, held in wide signed form.
  localparam logic signed [65:0] RES_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] RES_MIN = ~RES_MAX;

  // Classified item as it sits in the queue.
  typedef struct packed {
    op_t                op;
    logic               is_long;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } item_t;

  // One finished result.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t            status;
  } res_t;

  // Work handed from the back to the iterative unit.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] ar;
    logic               ai_neg;
    logic signed [65:0] num_re;
    logic signed [65:0] num_im;
    logic [63:0]        sumsq;
  } seq_req_t;

  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // Working pair of the bitwise integer square root.
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } root_t;

  // Clamp a wide signed value to the 32-bit range and flag the clamp.
  function automatic sat_t saturate(input logic signed [65:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > RES_MAX) begin
      s.ovf = 1'b1;
      s.val = RES_MAX[31:0];
    end else if (v < RES_MIN) begin
      s.ovf = 1'b1;
      s.val = RES_MIN[31:0];
    end
    return s;
  endfunction

  // One step of the integer square root; probe walks down two bits a step.
  function automatic root_t root_step(input root_t x, input logic [63:0] probe);
    root_t      y;
    logic [64:0] trial;
    trial = {1'b0, x.r} + {1'b0, probe};
    if ({1'b0, x.v} >= trial) begin
      y.v = x.v - trial[63:0];
      y.r = (x.r >> 1) + probe;
    end else begin
      y.v = x.v;
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [64:0] div_step(input logic [63:0] rem, input logic [63:0] dvs,
                                           input logic inb);
    logic [64:0] t;
    logic [64:0] diff;
    t    = {rem, inb};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, diff[63:0]};
    end
    return {1'b0, t[63:0]};
  endfunction

endpackage

@@ rtl/core/cau_front.sv @@
module cau_front import cau_pkg::*; (
  input  logic        in_valid,
  input  logic [2:0]  op,
  input  logic [31:0] a_re,
  input  logic [31:0] a_im,
  input  logic [31:0] b_re,
  input  logic [31:0] b_im,
  input  logic        q_full,
  output logic        in_stall,
  output logic        push,
  output item_t       item
);

  logic dz;

  // Classify the transaction: long operations go to the iterative unit.
  always_comb begin
    dz            = (b_re == 32'd0) && (b_im == 32'd0);
    item.op       = op_t'(op);
    item.ar       = a_re;
    item.ai       = a_im;
    item.br       = b_re;
    item.bi       = b_im;
    case (op_t'(op))
      OP_DIV:          item.is_long = !dz;
      OP_MAG, OP_SQRT: item.is_long = 1'b1;
      default:         item.is_long = 1'b0;
    endcase
  end

  // Accept whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

@@ rtl/core/cau_queue.sv @@
module cau_queue import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output item_t head
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

@@ rtl/core/cau_seq.sv @@
module cau_seq import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  seq_ctl_t  ctl,
  input  seq_req_t  req,
  output seq_stat_t stat,
  output res_t      res
);

  localparam int                SHR     = 32 - FRAC_BITS;
  localparam int                HALF_SH = FRAC_BITS - 1;
  localparam logic [STEP_W-1:0] LAST    = STEP_W'(STEPS - 1);
  localparam logic [63:0]       TOP     = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_DPREP, S_DCHK, S_DRUN, S_ROOT, S_HALF, S_ROOT2, S_FIN, S_DONE
  } state_t;

  state_t             state;
  op_t                op;
  logic signed [31:0] ar;
  logic               ai_neg;
  logic signed [65:0] num_re;
  logic signed [65:0] num_im;
  logic               neg_re;
  logic               neg_im;
  logic [63:0]        mag_re;
  logic [63:0]        mag_im;
  logic [63:0]        dvs;
  logic [63:0]        rem_re;
  logic [63:0]        rem_im;
  logic [31:0]        feed_re;
  logic [31:0]        feed_im;
  logic [31:0]        q_re;
  logic [31:0]        q_im;
  logic               ovf_re;
  logic               ovf_im;
  root_t              eng_a;
  root_t              eng_b;
  logic [63:0]        probe;
  logic [STEP_W-1:0]  cnt;

  root_t              step_a;
  root_t              step_b;
  logic [64:0]        dstep_re;
  logic [64:0]        dstep_im;
  logic signed [65:0] abs_re;
  logic signed [65:0] abs_im;
  logic [63:0]        hi_re;
  logic [63:0]        hi_im;
  logic signed [34:0] m35;
  logic signed [34:0] mx;
  logic signed [34:0] nx;
  logic [63:0]        mx_sh;
  logic [63:0]        nx_sh;
  logic [32:0]        qm_re;
  logic [32:0]        qm_im;
  logic signed [65:0] v_re;
  logic signed [65:0] v_im;
  sat_t               s_re;
  sat_t               s_im;
  res_t               fin_res;

  // Step logic of the shared divider and root engines.
  always_comb begin
    step_a   = root_step(eng_a, probe);
    step_b   = root_step(eng_b, probe);
    dstep_re = div_step(rem_re, dvs, feed_re[31]);
    dstep_im = div_step(rem_im, dvs, feed_im[31]);
    abs_re   = num_re[65] ? -num_re : num_re;
    abs_im   = num_im[65] ? -num_im : num_im;
    hi_re    = mag_re >> SHR;
    hi_im    = mag_im >> SHR;
    m35      = $signed({3'b000, eng_a.r[31:0]});
    mx       = m35 + 35'(ar);
    nx       = m35 - 35'(ar);
    mx_sh    = {30'd0, mx[33:0]} << HALF_SH;
    nx_sh    = {30'd0, nx[33:0]} << HALF_SH;
  end

  // Final result forming and saturation.
  always_comb begin
    qm_re = ovf_re ? 33'h1_0000_0000 : {1'b0, q_re};
    qm_im = ovf_im ? 33'h1_0000_0000 : {1'b0, q_im};
    case (op)
      OP_DIV: begin
        v_re = neg_re ? -$signed({33'd0, qm_re}) : $signed({33'd0, qm_re});
        v_im = neg_im ? -$signed({33'd0, qm_im}) : $signed({33'd0, qm_im});
      end
      OP_MAG: begin
        v_re = $signed({2'b00, eng_a.r});
        v_im = '0;
      end
      default: begin
        v_re = $signed({2'b00, eng_a.r});
        v_im = ai_neg ? -$signed({2'b00, eng_b.r}) : $signed({2'b00, eng_b.r});
      end
    endcase
    s_re           = saturate(v_re);
    s_im           = saturate(v_im);
    fin_res.re     = s_re.val;
    fin_res.im     = s_im.val;
    fin_res.status = (s_re.ovf || s_im.ovf) ? ST_SAT : ST_OK;
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  // Sequencer: divide runs prep, check and the bit steps; roots run one or two passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            op     <= req.op;
            ar     <= req.ar;
            ai_neg <= req.ai_neg;
            num_re <= req.num_re;
            num_im <= req.num_im;
            dvs    <= req.sumsq;
            eng_a  <= '{v: req.sumsq, r: 64'd0};
            probe  <= TOP;
            cnt    <= '0;
            state  <= (req.op == OP_DIV) ? S_DPREP : S_ROOT;
          end
        end
        S_DPREP: begin
          neg_re <= num_re[65];
          neg_im <= num_im[65];
          mag_re <= abs_re[63:0];
          mag_im <= abs_im[63:0];
          state  <= S_DCHK;
        end
        S_DCHK: begin
          ovf_re  <= (hi_re >= dvs);
          ovf_im  <= (hi_im >= dvs);
          rem_re  <= hi_re;
          rem_im  <= hi_im;
          feed_re <= {mag_re[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
          feed_im <= {mag_im[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
          q_re    <= '0;
          q_im    <= '0;
          cnt     <= '0;
          state   <= S_DRUN;
        end
        S_DRUN: begin
          rem_re  <= dstep_re[63:0];
          rem_im  <= dstep_im[63:0];
          q_re    <= {q_re[30:0], dstep_re[64]};
          q_im    <= {q_im[30:0], dstep_im[64]};
          feed_re <= feed_re << 1;
          feed_im <= feed_im << 1;
          cnt     <= cnt + STEP_W'(1);
          if (cnt == LAST) state <= S_FIN;
        end
        S_ROOT: begin
          eng_a <= step_a;
          probe <= probe >> 2;
          cnt   <= cnt + STEP_W'(1);
          if (cnt == LAST) state <= (op == OP_SQRT) ? S_HALF : S_FIN;
        end
        S_HALF: begin
          eng_a <= '{v: mx_sh, r: 64'd0};
          eng_b <= '{v: nx_sh, r: 64'd0};
          probe <= TOP;
          cnt   <= '0;
          state <= S_ROOT2;
        end
        S_ROOT2: begin
          eng_a <= step_a;
          eng_b <= step_b;
          probe <= probe >> 2;
          cnt   <= cnt + STEP_W'(1);
          if (cnt == LAST) state <= S_FIN;
        end
        S_FIN: begin
          res   <= fin_res;
          state <= S_DONE;
        end
        S_DONE: begin
          if (ctl.ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/cau_back.sv @@
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  item_t     q_head,
  output logic      q_pop,
  input  seq_stat_t seq_stat,
  output seq_ctl_t  seq_ctl,
  output seq_req_t  seq_req,
  input  res_t      seq_res,
  output logic      out_valid,
  input  logic      out_stall,
  output res_t      out_res
);

  logic               s1_valid;
  item_t              s1;
  logic signed [63:0] p_rr;
  logic signed [63:0] p_ii;
  logic signed [63:0] p_ri;
  logic signed [63:0] p_ir;
  logic signed [63:0] p_xx;
  logic signed [63:0] p_yy;

  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [65:0] v_re;
  logic signed [65:0] v_im;
  sat_t               s_re;
  sat_t               s_im;
  res_t               simple_res;
  logic               out_free;
  logic               s1_leave;

  // Truncate a scaled product toward zero.
  function automatic logic signed [65:0] trunc_frac(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v >>> FRAC_BITS;
    if (v[65] && (v[FRAC_BITS-1:0] != '0)) t = t + 66'sd1;
    return t;
  endfunction

  // Squares use the divisor for a quotient and the first operand otherwise.
  assign sq_x = (q_head.op == OP_DIV) ? q_head.br : q_head.ar;
  assign sq_y = (q_head.op == OP_DIV) ? q_head.bi : q_head.ai;

  // Single-pass operations evaluated in the product stage.
  always_comb begin
    case (s1.op)
      OP_ADD: begin
        v_re = 66'(s1.ar) + 66'(s1.br);
        v_im = 66'(s1.ai) + 66'(s1.bi);
      end
      OP_SUB: begin
        v_re = 66'(s1.ar) - 66'(s1.br);
        v_im = 66'(s1.ai) - 66'(s1.bi);
      end
      OP_MUL: begin
        v_re = trunc_frac(66'(p_rr) - 66'(p_ii));
        v_im = trunc_frac(66'(p_ri) + 66'(p_ir));
      end
      OP_CONJ: begin
        v_re = 66'(s1.ar);
        v_im = -66'(s1.ai);
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
    s_re          = saturate(v_re);
    s_im          = saturate(v_im);
    simple_res.re = s_re.val;
    simple_res.im = s_im.val;
    if (s1.op == OP_DIV) begin
      simple_res.status = ST_DIV_ZERO;
    end else begin
      simple_res.status = (s_re.ovf || s_im.ovf) ? ST_SAT : ST_OK;
    end
  end

  // Operands for the iterative unit.
  always_comb begin
    seq_req.op     = s1.op;
    seq_req.ar     = s1.ar;
    seq_req.ai_neg = s1.ai[31];
    seq_req.num_re = 66'(p_rr) + 66'(p_ii);
    seq_req.num_im = 66'(p_ir) - 66'(p_ri);
    seq_req.sumsq  = $unsigned(p_xx) + $unsigned(p_yy);
  end

  // Stage handoff.
  assign out_free      = !out_valid || !out_stall;
  assign s1_leave      = s1_valid && (!s1.is_long || seq_stat.done) && out_free;
  assign q_pop         = q_valid && (!s1_valid || s1_leave);
  assign seq_ctl.start = s1_valid && s1.is_long && seq_stat.idle;
  assign seq_ctl.ack   = s1_leave && s1.is_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_leave) begin
        s1_valid <= 1'b0;
      end
      if (s1_leave) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Product stage and output register payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1   <= q_head;
      p_rr <= q_head.ar * q_head.br;
      p_ii <= q_head.ai * q_head.bi;
      p_ri <= q_head.ar * q_head.bi;
      p_ir <= q_head.ai * q_head.br;
      p_xx <= sq_x * sq_x;
      p_yy <= sq_y * sq_y;
    end
    if (s1_leave) begin
      out_res <= s1.is_long ? seq_res : simple_res;
    end
  end

endmodule

@@ rtl/core/complex_arithmetic_unit_core.sv @@
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+------------------------------------
// input    | in_valid in, in_stall out   | op, a_re, a_im, b_re, b_im
// output   | out_valid out, out_stall in | res_re, res_im, status
//
// Add, subtract, multiply, conjugate and division by zero take one transaction
// per cycle unless the output stalls or a long operation is ahead, via the queue,
// the product stage and the output register. Divide, magnitude and square root use
// the shared iterative divide and root unit; later transactions wait behind it.
// Reset is synchronous and clears the queue and all valid flags.
// A stall on the output holds the result; the four-entry queue keeps input open meanwhile.
module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [31:0] a_re,
  input  logic [31:0] a_im,
  input  logic [31:0] b_re,
  input  logic [31:0] b_im,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] res_re,
  output logic [31:0] res_im,
  output logic [1:0]  status
);

  logic      push;
  item_t     push_item;
  logic      q_full;
  logic      q_valid;
  item_t     q_head;
  logic      q_pop;
  seq_ctl_t  seq_ctl;
  seq_stat_t seq_stat;
  seq_req_t  seq_req;
  res_t      seq_res;
  res_t      out_res;

  cau_front u_front (
    .in_valid (in_valid),
    .op       (op),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .item     (push_item)
  );

  cau_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_item),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .head  (q_head)
  );

  cau_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .ctl  (seq_ctl),
    .req  (seq_req),
    .stat (seq_stat),
    .res  (seq_res)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .seq_stat  (seq_stat),
    .seq_ctl   (seq_ctl),
    .seq_req   (seq_req),
    .seq_res   (seq_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign res_re = out_res.re;
  assign res_im = out_res.im;
  assign status = out_res.status;

endmodule

@@ tb/complex_arithmetic_unit_core_test.sv @@
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_test;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    status_t     st;
  } cplx_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [31:0] a_re;
  logic [31:0] a_im;
  logic [31:0] b_re;
  logic [31:0] b_im;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] res_re;
  logic [31:0] res_im;
  logic [1:0]  status;

  cplx_result_t pending_results[$];
  int           error_count = 0;
  bit           quiet = 0;
  int           hold_left = 0;

  complex_arithmetic_unit_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_re(res_re), .res_im(res_im), .status(status)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor of the square root of a non-negative value below 2^64.
  function automatic logic [31:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] t;
    logic [31:0]  r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = {96'd0, r | (32'd1 << i)};
      if (t * t <= v) r = t[31:0];
    end
    return r;
  endfunction

  // Clamp to the 32-bit signed range, flagging any clamp.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit ovf);
    if (v > QMAX) begin
      ovf = 1;
      return QMAX;
    end
    if (v < QMIN) begin
      ovf = 1;
      return QMIN;
    end
    return v[31:0];
  endfunction

  // Scale down by the fraction width, truncating toward zero.
  function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
    if (v < 0) return -((-v) >>> FRAC);
    return v >>> FRAC;
  endfunction

  // Quotient n * 2^FRAC / d truncated toward zero, d positive.
  function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
    logic signed [127:0] q;
    q = ((n < 0 ? -n : n) <<< FRAC) / d;
    return n < 0 ? -q : q;
  endfunction

  // Expected result of one complex operation.
  function automatic cplx_result_t calc_complex(input logic [2:0] code,
                                                input logic signed [31:0] ar,
                                                input logic signed [31:0] ai,
                                                input logic signed [31:0] br,
                                                input logic signed [31:0] bi);
    logic signed [127:0] xr, xi, yr, yi, re, im, d, m;
    cplx_result_t        res;
    bit                  ovf;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    re = 0;
    im = 0;
    ovf = 0;
    res.st = ST_OK;
    case (code)
      OP_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      OP_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      OP_MUL: begin
        re = drop_frac(xr * yr - xi * yi);
        im = drop_frac(xr * yi + xi * yr);
      end
      OP_DIV: begin
        d = yr * yr + yi * yi;
        if (d == 0) begin
          res.st = ST_DIV_ZERO;
        end else begin
          re = scaled_quot(xr * yr + xi * yi, d);
          im = scaled_quot(xi * yr - xr * yi, d);
        end
      end
      OP_MAG: begin
        re = floor_sqrt(xr * xr + xi * xi);
      end
      OP_CONJ: begin
        re = xr;
        im = -xi;
      end
      OP_SQRT: begin
        m = floor_sqrt(xr * xr + xi * xi);
        re = floor_sqrt((m + xr) <<< (FRAC - 1));
        im = floor_sqrt((m - xr) <<< (FRAC - 1));
        if (ai < 0) im = -im;
      end
      default: ;
    endcase
    res.re = clamp32(re, ovf);
    res.im = clamp32(im, ovf);
    if (ovf && res.st == ST_OK) res.st = ST_SAT;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Send one transaction after a random idle gap, none while quiet; expectation is queued on acceptance.
  task automatic send_item(input logic [2:0] code, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    a_re <= ar;
    a_im <= ai;
    b_re <= br;
    b_im <= bi;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(calc_complex(code, ar, ai, br, bi));
  endtask

  // Operand with a bias toward small values and the range limits.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 8 * ONE) - 4 * ONE;
      1: return $urandom_range(0, 1) ? QMAX : QMIN;
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 2000 * ONE) - 1000 * ONE;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_item(OP_ADD, QMAX, QMIN, QMAX, QMIN);
    send_item(OP_SUB, QMIN, QMAX, QMAX, QMIN);
    send_item(OP_MUL, QMIN, QMIN, QMIN, QMIN);
    send_item(OP_MUL, QMAX, QMIN, QMAX, QMAX);
    send_item(OP_DIV, QMAX, QMIN, 32'sd1, 32'sd0);
    send_item(OP_DIV, QMIN, QMIN, QMIN, QMIN);
    send_item(OP_MAG, QMIN, QMIN, 32'd0, 32'd0);
    send_item(OP_SQRT, QMIN, QMIN, 32'd0, 32'd0);
    send_item(OP_SQRT, QMAX, QMAX, 32'd0, 32'd0);
    send_item(OP_CONJ, QMIN, QMIN, QMAX, QMAX);
  endtask

  task automatic test_each_op();
    send_item(OP_ADD, ONE, 2 * ONE, -3 * ONE, ONE);
    send_item(OP_SUB, ONE, 2 * ONE, -3 * ONE, ONE);
    send_item(OP_MUL, 2 * ONE, -ONE, ONE / 2, 3 * ONE);
    send_item(OP_DIV, 5 * ONE, ONE, 2 * ONE, -ONE);
    send_item(OP_MAG, 3 * ONE, -4 * ONE, $urandom, $urandom);
    send_item(OP_CONJ, -7 * ONE, 5 * ONE, $urandom, $urandom);
    send_item(OP_SQRT, -4 * ONE, 32'd0, $urandom, $urandom);
    send_item(OP_SQRT, 32'd0, -2 * ONE, 32'd0, 32'd0);
  endtask

  task automatic test_special_cases();
    // Zero divisor, unused code, a conjugate of the most negative value, a saturating add and a saturating divide.
    send_item(OP_DIV, ONE, ONE, 32'd0, 32'd0);
    send_item(OP_DIV, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    send_item(OP_CONJ, ONE, QMIN, 32'd0, 32'd0);
    send_item(OP_ADD, QMAX, QMAX, 32'sd1, 32'sd1);
    send_item(OP_DIV, QMAX, 32'd0, 32'sd1, 32'sd1);
  endtask

  task automatic test_random(input int count);
    logic [2:0]  code;
    logic [31:0] br;
    logic [31:0] bi;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      code = 3'($urandom_range(0, 7));
      br = rand_operand();
      bi = rand_operand();
      if (code == OP_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(code, rand_operand(), rand_operand(), br, bi);
    end
    quiet = 0;
  endtask

  // Output stall: a random hold before each result, none while quiet.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    cplx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      hold_left <= quiet ? 0 : $urandom_range(0, 19);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (res_re !== want.re) report_mismatch("res_re", res_re, want.re);
        if (res_im !== want.im) report_mismatch("res_im", res_im, want.im);
        if (status !== want.st) report_mismatch("status", {30'd0, status}, {30'd0, want.st});
      end
    end
  end

  // Hard limit on run length.
  initial begin
    #50ms;
    $display("complex_arithmetic_unit_core_test: errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    op = '0;
    a_re = '0;
    a_im = '0;
    b_re = '0;
    b_im = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_each_op();
    test_special_cases();
    test_random(1050);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("complex_arithmetic_unit_core_test: clean");
    end else begin
      $display("complex_arithmetic_unit_core_test: errors");
    end
    $finish;
  end

endmodule
